// ----- rtl/lavm_pkg.sv -----
`default_nettype none
package lavm_pkg;

  // Register stages through one normalizer: input, six shift steps, square,
  // sum, 32 root steps, divide setup, 31 quotient steps, output.
  localparam int unsigned NORM_LAT = 74;
  // Input register, two normalizers, two cross stages, six tail stages.
  localparam int unsigned TOP_LAT  = 1 + 2 * NORM_LAT + 2 + 6;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Items carried alongside a vector through the normalizer.
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] aux;
  } lavm_side_t;

  // Shift right by 30, round half away from zero.
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? (~x + 64'd1) : x;
    r = (mag + 64'd536870912) >> 30;
    rnd30 = x[63] ? $signed(~r + 64'd1) : $signed(r);
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] x);
    if (x > 64'sd1073741824) begin
      clamp_unit = ONE_Q30;
    end else if (x < -64'sd1073741824) begin
      clamp_unit = -ONE_Q30;
    end else begin
      clamp_unit = x[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      sat32 = 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lavm_norm.sv -----
`default_nettype none
module lavm_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2:0][63:0]    vec_i,
  input  lavm_pkg::lavm_side_t side_i,
  output logic                valid_o,
  output logic [2:0][31:0]    unit_o,
  output lavm_pkg::lavm_side_t side_o
);
  import lavm_pkg::*;

  localparam int unsigned ST_OUT = NORM_LAT - 1;

  typedef struct packed {
    lavm_side_t side;
    logic [2:0] neg;
    logic       zero;
  } carry_t;

  logic   vld_q [0:ST_OUT];
  carry_t cy_q  [0:ST_OUT];

  logic [63:0] sh_q   [0:6][0:2];
  logic [29:0] a_q    [0:33][0:2];
  logic [59:0] sq_q   [0:2];
  logic [63:0] rem_q  [0:32];
  logic [63:0] res_q  [0:32];
  logic [60:0] num_q  [0:31][0:2];
  logic [30:0] den_q  [0:31];
  logic [30:0] quo_q  [0:31][0:2];
  logic [2:0][31:0] unit_q;

  // Control: valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ST_OUT; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= ST_OUT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Input stage: magnitudes and signs.
  always_ff @(posedge clk_i) begin
    cy_q[0].side <= side_i;
    cy_q[0].zero <= (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
    for (int c = 0; c < 3; c++) begin
      cy_q[0].neg[c] <= vec_i[c][63];
      sh_q[0][c]     <= vec_i[c][63] ? (~vec_i[c] + 64'd1) : vec_i[c];
    end
    for (int k = 1; k <= ST_OUT; k++) cy_q[k] <= cy_q[k-1];
  end

  // Leading-one alignment: the OR of the magnitudes leads where the largest does.
  for (genvar g = 0; g < 6; g++) begin : g_shift
    localparam int unsigned AMT = 32 >> g;
    logic [63:0] orv;
    logic        hit;
    assign orv = sh_q[g][0] | sh_q[g][1] | sh_q[g][2];
    assign hit = (orv[63 -: AMT] == '0);
    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 3; c++) begin
        sh_q[g+1][c] <= hit ? (sh_q[g][c] << AMT) : sh_q[g][c];
      end
    end
  end

  // Square, then sum.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      a_q[0][c] <= sh_q[6][c][63:34];
      sq_q[c]   <= sh_q[6][c][63:34] * sh_q[6][c][63:34];
      a_q[1][c] <= a_q[0][c];
    end
    rem_q[0] <= {4'd0, sq_q[0]} + {4'd0, sq_q[1]} + {4'd0, sq_q[2]};
    res_q[0] <= '0;
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (rem_q[k] >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial;
        res_q[k+1] <= (res_q[k] >> 1) + BIT;
      end else begin
        rem_q[k+1] <= rem_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
      for (int c = 0; c < 3; c++) a_q[k+2][c] <= a_q[k+1][c];
    end
  end

  // Divide setup: a * 2^30 + s/2 over s.
  always_ff @(posedge clk_i) begin
    den_q[0] <= res_q[32][30:0];
    for (int c = 0; c < 3; c++) begin
      num_q[0][c] <= {1'b0, a_q[33][c], 30'd0} + {31'd0, res_q[32][30:1]};
      quo_q[0][c] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar g = 0; g < 31; g++) begin : g_div
    localparam int unsigned BP = 30 - g;
    logic [61:0] trial;
    assign trial = {31'd0, den_q[g]} << BP;
    always_ff @(posedge clk_i) begin
      den_q[g+1] <= den_q[g];
      for (int c = 0; c < 3; c++) begin
        if ({1'b0, num_q[g][c]} >= trial) begin
          num_q[g+1][c] <= num_q[g][c] - trial[60:0];
          quo_q[g+1][c] <= quo_q[g][c] | (31'd1 << BP);
        end else begin
          num_q[g+1][c] <= num_q[g][c];
          quo_q[g+1][c] <= quo_q[g][c];
        end
      end
    end
  end

  // Clamp, apply sign, force zero for a zero vector.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      logic [31:0] q;
      q = (quo_q[31][c] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, quo_q[31][c]};
      if (cy_q[ST_OUT-1].zero) begin
        unit_q[c] <= '0;
      end else begin
        unit_q[c] <= cy_q[ST_OUT-1].neg[c] ? (~q + 32'd1) : q;
      end
    end
  end

  assign valid_o = vld_q[ST_OUT];
  assign unit_o  = unit_q;
  assign side_o  = cy_q[ST_OUT].side;

`ifndef ASSERT_OFF
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(NORM_LAT) valid_o) else $error("normalizer lost an item");
  a_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !cy_q[ST_OUT].zero |-> (unit_o != '0))
    else $error("nonzero vector normalized to zero");
  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cy_q[ST_OUT].zero |-> (unit_o == '0))
    else $error("zero vector gave nonzero unit");
`endif

endmodule
`default_nettype wire

// ----- rtl/look_at_view_matrix.sv -----
`default_nettype none
// Look-at view matrix builder.
// Command channel: drive eye, target and upward coordinates (signed Q16.16)
// with start high; an item is taken at the clock edge where start is high
// and busy is low. busy stays low, so an item can enter every cycle.
// Result channel: done_o marks the one cycle in which the three top rows of
// the view matrix sit on the result ports (axes in Q2.30, offsets in
// saturated Q16.16). The receiver cannot hold results off; each is shown
// once and is gone the next cycle.
// Throughput: one item per cycle. Most of the pipeline lies in the two vector
// normalizers, each a 32-step square root pipeline followed by a 31-step
// restoring divider, with one root bit or quotient bit per stage.
// Reset clears all valid bits at once; items in flight are dropped and no
// done_o follows for them. There is no clearing pass.
module look_at_view_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [31:0] upward_x_i,
  input  logic [31:0] upward_y_i,
  input  logic [31:0] upward_z_i,
  output logic        done_o,
  output logic [31:0] side_x_o,
  output logic [31:0] side_y_o,
  output logic [31:0] side_z_o,
  output logic [31:0] side_offset_o,
  output logic [31:0] vert_x_o,
  output logic [31:0] vert_y_o,
  output logic [31:0] vert_z_o,
  output logic [31:0] vert_offset_o,
  output logic [31:0] fwd_x_o,
  output logic [31:0] fwd_y_o,
  output logic [31:0] fwd_z_o,
  output logic [31:0] fwd_offset_o
);
  import lavm_pkg::*;

  // Axes and offsets carried through the tail stages.
  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][31:0] f;
    logic [2:0][31:0] e;
    logic [2:0][31:0] v;
    logic [31:0]      soff;
    logic [31:0]      foff;
  } row_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input stage: exact difference target minus eye.
  logic             v0_q;
  logic [2:0][63:0] dif_q;
  lavm_side_t       sd0_q;

  // First normalizer: forward axis.
  logic             n1_vld;
  logic [2:0][31:0] n1_unit;
  lavm_side_t       n1_side;

  // Cross stages: upward x forward.
  logic             c1_vld_q, c2_vld_q;
  logic signed [63:0] c1_p_q [0:5];
  lavm_side_t       c1_side_q, c2_side_q;
  logic [2:0][63:0] c2_vec_q;

  // Second normalizer: side axis.
  logic             n2_vld;
  logic [2:0][31:0] n2_unit;
  lavm_side_t       n2_side;

  // Tail stages.
  logic               p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q, p6_vld_q;
  row_t               p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [63:0] p1_vp_q [0:5];
  logic signed [63:0] p1_sp_q [0:2];
  logic signed [63:0] p1_fp_q [0:2];
  logic signed [63:0] p2_vc_q [0:2];
  logic signed [63:0] p2_sdot_q, p2_fdot_q;
  logic signed [63:0] p4_vp_q [0:2];
  logic signed [63:0] p5_vdot_q;
  logic [31:0]        p6_voff_q;

  // Advance valid bits every cycle; nothing downstream can stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
      p6_vld_q <= 1'b0;
    end else begin
      v0_q     <= accept;
      c1_vld_q <= n1_vld;
      c2_vld_q <= c1_vld_q;
      p1_vld_q <= n2_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
      p6_vld_q <= p5_vld_q;
    end
  end

  // Capture the item and form the 33-bit difference.
  always_ff @(posedge clk_i) begin
    dif_q[0]  <= {{32{target_x_i[31]}}, target_x_i} - {{32{eye_x_i[31]}}, eye_x_i};
    dif_q[1]  <= {{32{target_y_i[31]}}, target_y_i} - {{32{eye_y_i[31]}}, eye_y_i};
    dif_q[2]  <= {{32{target_z_i[31]}}, target_z_i} - {{32{eye_z_i[31]}}, eye_z_i};
    sd0_q.eye <= {eye_z_i, eye_y_i, eye_x_i};
    sd0_q.aux <= {upward_z_i, upward_y_i, upward_x_i};
  end

  lavm_norm u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (dif_q),
    .side_i  (sd0_q),
    .valid_o (n1_vld),
    .unit_o  (n1_unit),
    .side_o  (n1_side)
  );

  // Upward x forward: products, then differences (exact Q18.46).
  always_ff @(posedge clk_i) begin
    c1_p_q[0] <= $signed(n1_side.aux[1]) * $signed(n1_unit[2]);
    c1_p_q[1] <= $signed(n1_side.aux[2]) * $signed(n1_unit[1]);
    c1_p_q[2] <= $signed(n1_side.aux[2]) * $signed(n1_unit[0]);
    c1_p_q[3] <= $signed(n1_side.aux[0]) * $signed(n1_unit[2]);
    c1_p_q[4] <= $signed(n1_side.aux[0]) * $signed(n1_unit[1]);
    c1_p_q[5] <= $signed(n1_side.aux[1]) * $signed(n1_unit[0]);
    c1_side_q.eye <= n1_side.eye;
    c1_side_q.aux <= n1_unit;
    c2_vec_q[0] <= c1_p_q[0] - c1_p_q[1];
    c2_vec_q[1] <= c1_p_q[2] - c1_p_q[3];
    c2_vec_q[2] <= c1_p_q[4] - c1_p_q[5];
    c2_side_q   <= c1_side_q;
  end

  lavm_norm u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c2_vld_q),
    .vec_i   (c2_vec_q),
    .side_i  (c2_side_q),
    .valid_o (n2_vld),
    .unit_o  (n2_unit),
    .side_o  (n2_side)
  );

  // Tail: forward x side for the up axis, dot products with the eye.
  always_ff @(posedge clk_i) begin
    p1_q.s    <= n2_unit;
    p1_q.f    <= n2_side.aux;
    p1_q.e    <= n2_side.eye;
    p1_q.v    <= '0;
    p1_q.soff <= '0;
    p1_q.foff <= '0;
    p1_vp_q[0] <= $signed(n2_side.aux[1]) * $signed(n2_unit[2]);
    p1_vp_q[1] <= $signed(n2_side.aux[2]) * $signed(n2_unit[1]);
    p1_vp_q[2] <= $signed(n2_side.aux[2]) * $signed(n2_unit[0]);
    p1_vp_q[3] <= $signed(n2_side.aux[0]) * $signed(n2_unit[2]);
    p1_vp_q[4] <= $signed(n2_side.aux[0]) * $signed(n2_unit[1]);
    p1_vp_q[5] <= $signed(n2_side.aux[1]) * $signed(n2_unit[0]);
    for (int c = 0; c < 3; c++) begin
      p1_sp_q[c] <= $signed(n2_unit[c]) * $signed(n2_side.eye[c]);
      p1_fp_q[c] <= $signed(n2_side.aux[c]) * $signed(n2_side.eye[c]);
    end

    p2_q       <= p1_q;
    p2_vc_q[0] <= p1_vp_q[0] - p1_vp_q[1];
    p2_vc_q[1] <= p1_vp_q[2] - p1_vp_q[3];
    p2_vc_q[2] <= p1_vp_q[4] - p1_vp_q[5];
    p2_sdot_q  <= p1_sp_q[0] + p1_sp_q[1] + p1_sp_q[2];
    p2_fdot_q  <= p1_fp_q[0] + p1_fp_q[1] + p1_fp_q[2];

    // Round the up axis back to Q2.30; negate, round and saturate offsets.
    p3_q.s <= p2_q.s;
    p3_q.f <= p2_q.f;
    p3_q.e <= p2_q.e;
    for (int c = 0; c < 3; c++) p3_q.v[c] <= clamp_unit(rnd30(p2_vc_q[c]));
    p3_q.soff <= sat32(rnd30(-p2_sdot_q));
    p3_q.foff <= sat32(rnd30(-p2_fdot_q));

    p4_q <= p3_q;
    for (int c = 0; c < 3; c++) p4_vp_q[c] <= $signed(p3_q.v[c]) * $signed(p3_q.e[c]);

    p5_q      <= p4_q;
    p5_vdot_q <= p4_vp_q[0] + p4_vp_q[1] + p4_vp_q[2];

    p6_q      <= p5_q;
    p6_voff_q <= sat32(rnd30(-p5_vdot_q));
  end

  assign done_o        = p6_vld_q;
  assign side_x_o      = p6_q.s[0];
  assign side_y_o      = p6_q.s[1];
  assign side_z_o      = p6_q.s[2];
  assign side_offset_o = p6_q.soff;
  assign vert_x_o      = p6_q.v[0];
  assign vert_y_o      = p6_q.v[1];
  assign vert_z_o      = p6_q.v[2];
  assign vert_offset_o = p6_voff_q;
  assign fwd_x_o       = p6_q.f[0];
  assign fwd_y_o       = p6_q.f[1];
  assign fwd_z_o       = p6_q.f[2];
  assign fwd_offset_o  = p6_q.foff;

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(TOP_LAT) done_o) else $error("item dropped or delayed");
  a_fwd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(fwd_x_o) <= ONE_Q30) && ($signed(fwd_x_o) >= -ONE_Q30) &&
               ($signed(fwd_y_o) <= ONE_Q30) && ($signed(fwd_y_o) >= -ONE_Q30) &&
               ($signed(fwd_z_o) <= ONE_Q30) && ($signed(fwd_z_o) >= -ONE_Q30))
    else $error("forward axis out of range");
  a_fwd_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (fwd_x_o == '0) && (fwd_y_o == '0) && (fwd_z_o == '0) |->
      (side_x_o == '0) && (side_y_o == '0) && (side_z_o == '0) &&
      (fwd_offset_o == '0) && (side_offset_o == '0))
    else $error("zero forward axis gave nonzero side row");
  a_side_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (side_x_o == '0) && (side_y_o == '0) && (side_z_o == '0) |->
      (vert_x_o == '0) && (vert_y_o == '0) && (vert_z_o == '0) &&
      (vert_offset_o == '0))
    else $error("zero side axis gave nonzero up row");
`endif

endmodule
`default_nettype wire

// ----- test/look_at_view_matrix_tb.sv -----
`default_nettype none
module look_at_view_matrix_tb;

  // One camera transform: three rows of axis plus offset.
  typedef struct packed {
    logic signed [31:0] sx, sy, sz, so;
    logic signed [31:0] vx, vy, vz, vo;
    logic signed [31:0] fx, fy, fz, fo;
  } view_rows_t;

  // Square root of a 64-bit value, rounded down.
  function automatic logic [63:0] root_floor(input logic [63:0] val);
    logic [63:0] res, bitv, s;
    res = 0;
    s = val;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] round_q30(input logic signed [63:0] x);
    logic [63:0] mag, r;
    mag = x < 0 ? -x : x;
    r = (mag + 64'd536870912) >> 30;
    return x < 0 ? -$signed(r) : $signed(r);
  endfunction

  // Scale a vector into [2^29, 2^30) and divide by its length.
  function automatic void unit_vec(input logic signed [63:0] v[3],
                                   output logic signed [63:0] u[3]);
    logic [63:0] m[3], a[3], mx, sum, s, q;
    int rs, ls;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    if (mx >= (64'd1 << 30)) while ((mx >> rs) >= (64'd1 << 30)) rs++;
    else while ((mx << ls) < (64'd1 << 29)) ls++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = rs != 0 ? (m[i] >> rs) : (m[i] << ls);
      sum = sum + a[i] * a[i];
    end
    s = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + s / 2) / s;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [31:0] row_offset(input logic signed [63:0] ax[3],
                                                   input logic signed [63:0] e[3]);
    logic signed [63:0] d;
    d = round_q30(-(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]));
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  function automatic view_rows_t build_view(input logic signed [31:0] c[9]);
    logic signed [63:0] e[3], t[3], up[3], dif[3], f[3], sc[3], sd[3], vt[3], r;
    view_rows_t o;
    for (int i = 0; i < 3; i++) begin
      e[i] = c[i];
      t[i] = c[3 + i];
      up[i] = c[6 + i];
      dif[i] = t[i] - e[i];
    end
    unit_vec(dif, f);
    sc[0] = up[1] * f[2] - up[2] * f[1];
    sc[1] = up[2] * f[0] - up[0] * f[2];
    sc[2] = up[0] * f[1] - up[1] * f[0];
    unit_vec(sc, sd);
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: r = f[1] * sd[2] - f[2] * sd[1];
        1: r = f[2] * sd[0] - f[0] * sd[2];
        default: r = f[0] * sd[1] - f[1] * sd[0];
      endcase
      r = round_q30(r);
      if (r > 64'sd1073741824) r = 64'sd1073741824;
      if (r < -64'sd1073741824) r = -64'sd1073741824;
      vt[i] = r;
    end
    o.sx = sd[0][31:0]; o.sy = sd[1][31:0]; o.sz = sd[2][31:0];
    o.vx = vt[0][31:0]; o.vy = vt[1][31:0]; o.vz = vt[2][31:0];
    o.fx = f[0][31:0];  o.fy = f[1][31:0];  o.fz = f[2][31:0];
    o.so = row_offset(sd, e);
    o.vo = row_offset(vt, e);
    o.fo = row_offset(f, e);
    return o;
  endfunction

  // Hold expected view matrices in issue order and compare each done_o.
  class view_board;
    view_rows_t pending[$];
    int errors;

    function void note_item(logic signed [31:0] c[9]);
      pending.push_back(build_view(c));
    endfunction

    function void check_rows(view_rows_t got);
      view_rows_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected view matrix out");
        return;
      end
      w = pending.pop_front();
      if (got != w) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp S %h %h %h %h V %h %h %h %h F %h %h %h %h",
                   w.sx, w.sy, w.sz, w.so, w.vx, w.vy, w.vz, w.vo,
                   w.fx, w.fy, w.fz, w.fo);
          $display("          got S %h %h %h %h V %h %h %h %h F %h %h %h %h",
                   got.sx, got.sy, got.sz, got.so, got.vx, got.vy, got.vz, got.vo,
                   got.fx, got.fy, got.fz, got.fo);
        end
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, done_o;
  logic [31:0] eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i;
  logic [31:0] upward_x_i, upward_y_i, upward_z_i;
  logic [31:0] side_x_o, side_y_o, side_z_o, side_offset_o;
  logic [31:0] vert_x_o, vert_y_o, vert_z_o, vert_offset_o;
  logic [31:0] fwd_x_o, fwd_y_o, fwd_z_o, fwd_offset_o;

  look_at_view_matrix dut (.*);

  view_board board = new();
  int idle_pct;
  int quiet_cycles;
  logic timed_out;

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Check results; watch for a stalled pipe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      view_rows_t got;
      got.sx = side_x_o; got.sy = side_y_o; got.sz = side_z_o; got.so = side_offset_o;
      got.vx = vert_x_o; got.vy = vert_y_o; got.vz = vert_z_o; got.vo = vert_offset_o;
      got.fx = fwd_x_o;  got.fy = fwd_y_o;  got.fz = fwd_z_o;  got.fo = fwd_offset_o;
      board.check_rows(got);
    end
    if ((start && !busy) || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  // Present one transform; hold until taken, with random idle gaps before.
  task automatic send_view(input logic signed [31:0] c[9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    eye_x_i <= c[0]; eye_y_i <= c[1]; eye_z_i <= c[2];
    target_x_i <= c[3]; target_y_i <= c[4]; target_z_i <= c[5];
    upward_x_i <= c[6]; upward_y_i <= c[7]; upward_z_i <= c[8];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(c);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 131071)) - 65536;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      3: return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom_range(0, 33554431)) - 16777216;
    endcase
  endfunction

  task automatic send_random();
    logic signed [31:0] c[9];
    for (int i = 0; i < 9; i++) c[i] = pick_coord();
    case ($urandom_range(9))
      0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];          // eye on target
      1: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i] - c[i]; // up along view
      2: for (int i = 0; i < 3; i++) c[6 + i] = 0;             // no up hint
      default: ;
    endcase
    send_view(c);
  endtask

  initial begin
    logic signed [31:0] c[9];
    logic signed [31:0] tmax, tmin;
    tmax = 32'sh7fff_ffff;
    tmin = 32'sh8000_0000;
    timed_out = 1'b0;
    quiet_cycles = 0;
    idle_pct = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    {eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i} <= '0;
    {upward_x_i, upward_y_i, upward_z_i} <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: standard camera, degenerate cases, extremes.
    c = '{0, 0, -32'sh50000, 0, 0, 0, 0, 32'sh10000, 0};
    send_view(c);
    c = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh10000, 32'sh20000, 32'sh30000,
          0, 32'sh10000, 0};
    send_view(c);
    c = '{0, 0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh10000};
    send_view(c);
    c = '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0};
    send_view(c);
    c = '{tmax, tmax, tmax, tmin, tmin, tmin, tmax, tmin, tmax};
    send_view(c);
    c = '{tmin, tmin, tmin, tmax, tmax, tmax, tmin, tmax, tmin};
    send_view(c);
    c = '{tmax, tmin, tmax, tmin, tmax, tmin, 0, tmax, 1};
    send_view(c);
    c = '{-1, -1, -1, 0, 0, 0, 1, -1, 1};
    send_view(c);
    c = '{tmin, 0, tmax, 0, tmin, 0, tmax, tmax, tmin};
    send_view(c);
    c = '{32'sh12345678, -32'sh0edcba98, 32'sh0, 32'sh1, 32'sh2, 32'sh3, -1, -1, -1};
    send_view(c);

    // Random phases: flat out, sparse, moderate, flat out again.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 79;
        2: idle_pct = 30;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 125; n++) send_random();
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- look_at_view_matrix.f -----
rtl/lavm_pkg.sv
rtl/lavm_norm.sv
rtl/look_at_view_matrix.sv
test/look_at_view_matrix_tb.sv
